// ----- rtl/core/smrc_pkg.sv -----
// shared types and constants of the shadow memory region controller
package smrc_pkg;

    localparam logic [7:0] ADDR_FIRST = 8'h22;
    localparam logic [7:0] ADDR_LAST  = 8'h2e;

    localparam int NUM_REGS = 7;
    localparam int NUM_SEGS = 16;

    localparam logic [2:0] SLOT_MC    = 3'd0;
    localparam logic [2:0] SLOT_CMP0  = 3'd1;
    localparam logic [2:0] SLOT_CMP1  = 3'd2;
    localparam logic [2:0] SLOT_RC    = 3'd3;
    localparam logic [2:0] SLOT_GRAN  = 3'd5;
    localparam logic [2:0] SLOT_GSEG  = 3'd6;

    localparam logic [15:0] RC_RESET = 16'h00f9;

    localparam logic [9:0] CMP_SIZE_SMALL = 10'd128;
    localparam logic [9:0] CMP_SIZE_LARGE = 10'd256;

    // granular segment index of the rom base 0xe0000 / 0xf0000, counted from 0xc0000
    localparam logic [2:0] ROM_IDX_E = 3'd4;
    localparam logic [2:0] ROM_IDX_F = 3'd6;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0]
    {
        SEG_EXT = 2'd0,
        SEG_RW  = 2'd1,
        SEG_RO  = 2'd2
    } seg_attr_t;

    typedef struct packed
    {
        logic        mode;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
    } item_t;

    typedef struct packed
    {
        logic        locked;
        logic        shadow_write;
        logic        shadow_read;
        logic [9:0]  remap_kb;
        logic [31:0] region_map;
        logic [15:0] read_data;
    } result_t;

endpackage

// ----- rtl/core/smrc_regs.sv -----
// port registers, region map state and per-access decode
module smrc_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  smrc_pkg::item_t  item,
    output smrc_pkg::result_t result
);

    logic [15:0]          regs_reg [smrc_pkg::NUM_REGS];
    logic [15:0]          regs_next [smrc_pkg::NUM_REGS];
    smrc_pkg::seg_attr_t  seg_reg [smrc_pkg::NUM_SEGS];
    smrc_pkg::seg_attr_t  seg_next [smrc_pkg::NUM_SEGS];
    logic                 lock_reg, lock_next;
    logic [9:0]           remap_reg, remap_next;
    logic                 shrd_reg, shrd_next;
    logic                 shwr_reg, shwr_next;

    logic                 decoded;
    logic [7:0]           addr_ofs;
    logic [2:0]           slot;
    logic                 is_write;

    function automatic logic [9:0] compare_size(input logic [15:0] r);
        logic [9:0] sz;
        sz = '0;
        if (r[0])
        begin
            sz = r[1] ? smrc_pkg::CMP_SIZE_SMALL : smrc_pkg::CMP_SIZE_LARGE;
        end
        return sz;
    endfunction

    assign decoded  = (item.reg_addr >= smrc_pkg::ADDR_FIRST) &&
                      (item.reg_addr <= smrc_pkg::ADDR_LAST) && !item.reg_addr[0];
    assign addr_ofs = item.reg_addr - smrc_pkg::ADDR_FIRST;
    assign slot     = addr_ofs[3:1];
    assign is_write = fire && item.mode;

    always_comb
    begin
        logic [15:0]         mc;
        logic [15:0]         g;
        logic                gran;
        smrc_pkg::seg_attr_t enabled;
        smrc_pkg::seg_attr_t attr;
        logic [2:0]          rom_idx;

        regs_next  = regs_reg;
        seg_next   = seg_reg;
        lock_next  = lock_reg;
        remap_next = remap_reg;
        shrd_next  = shrd_reg;
        shwr_next  = shwr_reg;
        attr       = smrc_pkg::SEG_EXT;

        if (is_write && decoded)
        begin
            regs_next[slot] = item.write_data;
        end

        mc      = regs_next[smrc_pkg::SLOT_MC];
        g       = regs_next[smrc_pkg::SLOT_GSEG];
        gran    = regs_next[smrc_pkg::SLOT_GRAN][0];
        enabled = mc[15] ? smrc_pkg::SEG_RO : smrc_pkg::SEG_RW;
        rom_idx = mc[8] ? smrc_pkg::ROM_IDX_E : smrc_pkg::ROM_IDX_F;

        // region effects only while unlocked, from the state before this beat
        if (is_write && decoded && !lock_reg)
        begin
            unique case (slot)
                smrc_pkg::SLOT_MC:
                begin
                    if (!gran)
                    begin
                        shrd_next = mc[0];
                        shwr_next = mc[0];
                        for (int k = 0; k < 4; k++)
                        begin
                            seg_next[k] = mc[3] ? smrc_pkg::SEG_RW : smrc_pkg::SEG_EXT;
                            if (!mc[10])
                            begin
                                seg_next[k + 4] = smrc_pkg::SEG_EXT;
                            end
                            else
                            begin
                                seg_next[k + 4] = mc[11] ? smrc_pkg::SEG_RW
                                                         : smrc_pkg::SEG_RO;
                            end
                            seg_next[k + 8]  = mc[9] ? enabled : smrc_pkg::SEG_EXT;
                            seg_next[k + 12] = mc[0] ? enabled : smrc_pkg::SEG_EXT;
                        end
                    end
                end
                smrc_pkg::SLOT_CMP0, smrc_pkg::SLOT_CMP1:
                begin
                    remap_next = compare_size(regs_next[smrc_pkg::SLOT_CMP0]) +
                                 compare_size(regs_next[smrc_pkg::SLOT_CMP1]);
                end
                smrc_pkg::SLOT_GSEG:
                begin
                    if (gran)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            if (!g[i + 8])
                            begin
                                attr = smrc_pkg::SEG_EXT;
                            end
                            else
                            begin
                                attr = g[i] ? smrc_pkg::SEG_RO : smrc_pkg::SEG_RW;
                            end
                            seg_next[i + 8] = attr;
                        end
                        shrd_next = g[{1'b1, rom_idx}];
                        shwr_next = g[{1'b0, rom_idx}];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (is_write)
        begin
            lock_next = mc[15];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < smrc_pkg::NUM_REGS; k++)
            begin
                regs_reg[k] <= '0;
            end
            regs_reg[smrc_pkg::SLOT_RC] <= smrc_pkg::RC_RESET;
            for (int k = 0; k < smrc_pkg::NUM_SEGS; k++)
            begin
                seg_reg[k] <= smrc_pkg::SEG_EXT;
            end
            lock_reg  <= 1'b0;
            remap_reg <= '0;
            shrd_reg  <= 1'b0;
            shwr_reg  <= 1'b0;
        end
        else if (fire)
        begin
            regs_reg  <= regs_next;
            seg_reg   <= seg_next;
            lock_reg  <= lock_next;
            remap_reg <= remap_next;
            shrd_reg  <= shrd_next;
            shwr_reg  <= shwr_next;
        end
    end

    always_comb
    begin
        result = '0;
        if (!item.mode && decoded)
        begin
            result.read_data = regs_reg[slot];
        end
        for (int k = 0; k < smrc_pkg::NUM_SEGS; k++)
        begin
            result.region_map[2*k +: 2] = seg_next[k];
        end
        result.remap_kb     = remap_next;
        result.shadow_read  = shrd_next;
        result.shadow_write = shwr_next;
        result.locked       = lock_next;
    end

endmodule

// ----- rtl/core/shadow_memory_region_controller.sv -----
// top level: input register, access decode and result register
//
//  channel | dir | fields
//  s_*     | in  | tuser: mode; tdata: reg_addr, write_data
//  m_*     | out | tdata: read_data, region_map, remap_kb, shadow_read,
//          |     |        shadow_write, locked
//
// one beat per cycle while m_tready is high; a beat passes the input then the result register
// the register file and region map update as a beat leaves the input register
// rst_n clears both pipeline valids, the lock, the region map; registers to 0, RC to 0x00f9
// a stall on m_tready holds the result and lets one more beat wait in the input register
module shadow_memory_region_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [smrc_pkg::IN_TDATA_W-1:0]     s_tdata,  // reg_addr[7:0], write_data[23:8]
    input  logic                                s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [smrc_pkg::OUT_TDATA_W-1:0]    m_tdata   // read_data[15:0], region_map[47:16],
                                                          // remap_kb[57:48], shadow_read[58],
                                                          // shadow_write[59], locked[60]
);

    logic                in_valid_reg;
    smrc_pkg::item_t     in_item_reg;
    logic                out_valid_reg;
    smrc_pkg::result_t   out_data_reg;
    smrc_pkg::result_t   result;
    logic                advance;
    logic                s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    smrc_regs u_regs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg.mode       <= s_tuser;
            in_item_reg.reg_addr   <= s_tdata[7:0];
            in_item_reg.write_data <= s_tdata[23:8];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(smrc_pkg::OUT_TDATA_W - $bits(smrc_pkg::result_t)){1'b0}},
                       out_data_reg};

endmodule

// ----- rtl/core/smrc_checker.sv -----
// port-level checks of the shadow memory region controller
module smrc_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [smrc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic        seen_reg;
    logic        lock_seen_reg;
    logic [43:0] state_seen_reg;

    // last delivered beat: lock flag and region state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            lock_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_reg      <= 1'b1;
            lock_seen_reg <= m_tdata[60];
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            state_seen_reg <= m_tdata[59:16];
        end
    end

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // while locked, no beat may change map, remap or shadow flags
    a_locked_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_reg && lock_seen_reg |-> m_tdata[59:16] == state_seen_reg)
        else $error("region state changed while locked");

endmodule

bind shadow_memory_region_controller smrc_checker u_smrc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
